### rtl/gtg_pkg.sv
// Package with constants and types shared by the go-to-goal steering unit.
`timescale 1ns / 1ps

package gtg_pkg;

  // Number of vectoring iterations of the bearing CORDIC (8 to 24).
  localparam int CORDIC_STEPS = 16;

  // A 33-bit squared distance gives a 17-bit root, one bit per step.
  localparam int SQRT_STEPS = 17;

  // Iteration stages shared by the root and the CORDIC lanes.
  localparam int ITER_STAGES = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;

  // Angles are in Q2.30 radians inside the datapath.
  localparam logic signed [34:0] ANG_PI     = 35'sd3373259426;
  localparam logic signed [34:0] ANG_TWO_PI = 35'sd6746518852;

  // atan(2^-i) in Q2.30, truncated.
  localparam logic [31:0] ATAN_TAB [24] = '{
    32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158,
    32'd67021686,  32'd33543515,  32'd16775850,  32'd8388437,
    32'd4194282,   32'd2097149,   32'd1048575,   32'd524287,
    32'd262143,    32'd131071,    32'd65535,     32'd32767,
    32'd16383,     32'd8191,      32'd4095,      32'd2047,
    32'd1023,      32'd511,       32'd255,       32'd127
  };

  // Configuration register indexes.
  localparam logic [1:0] REG_LINEAR_GAIN     = 2'd0;
  localparam logic [1:0] REG_ANGULAR_GAIN    = 2'd1;
  localparam logic [1:0] REG_ARRIVE_DISTANCE = 2'd2;

  // One stage of the iteration section: square root lane and CORDIC lane side by side.
  typedef struct packed {
    logic                vld;
    logic                arr;
    logic signed [14:0]  hd;
    logic [33:0]         rad;
    logic [17:0]         rem;
    logic [16:0]         root;
    logic signed [43:0]  cx;
    logic signed [43:0]  cy;
    logic signed [34:0]  cz;
  } iter_t;

endpackage

### rtl/go_to_goal_steering_unit.sv
// Top level of the go-to-goal steering unit: distance, bearing and proportional commands.
`timescale 1ns / 1ps

//  Channel   Signals                                       Handshake
//  -------   -------------------------------------------   ---------------------------------
//  request   start, busy, robot_x_i .. goal_y_i            taken when start && !busy
//  result    done_o, linear_speed_o, turn_rate_o,          valid for the single cycle that
//            arrived_o                                     done_o is high
//  config    cfg_we_i, cfg_idx_i, cfg_wdata_i              written when cfg_we_i is high
//
// The unit is a fully pipelined datapath: it takes one request every cycle and never
// raises busy. A request passes stage A, stage B, the iteration section, stages P1 to
// P3 and the output registers; the iteration section is as long as the longer of the
// 17-step square root and the CORDIC iterations, which run side by side, one step per stage.
// Reset clears the valid bits of all stages and loads the default gains and arrival distance; the
// receiver cannot stall, so nothing in the pipeline ever waits.
module go_to_goal_steering_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Request channel
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] robot_x_i,
  input  logic signed [15:0] robot_y_i,
  input  logic signed [14:0] robot_heading_i,
  input  logic signed [15:0] goal_x_i,
  input  logic signed [15:0] goal_y_i,
  // Result channel
  output logic               done_o,
  output logic [15:0]        linear_speed_o,
  output logic signed [15:0] turn_rate_o,
  output logic               arrived_o,
  // Configuration write port
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i
);

  // The pipeline never stalls, so a request is always welcome.
  assign busy = 1'b0;

  // ---------------------------------------------------------------------------
  // Configuration registers. The squared arrival threshold is kept in a register
  // of its own; the user must make configuration changes only while the pipeline is
  // empty, as the block does not enforce this, so that it is settled when a request needs it.
  // ---------------------------------------------------------------------------
  logic [15:0] linear_gain_q, angular_gain_q, arrive_distance_q;
  logic [31:0] thr2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      linear_gain_q     <= 16'd205;
      angular_gain_q    <= 16'd1536;
      arrive_distance_q <= 16'd128;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gtg_pkg::REG_LINEAR_GAIN:     linear_gain_q     <= cfg_wdata_i;
        gtg_pkg::REG_ANGULAR_GAIN:    angular_gain_q    <= cfg_wdata_i;
        gtg_pkg::REG_ARRIVE_DISTANCE: arrive_distance_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    thr2_q <= arrive_distance_q * arrive_distance_q;
  end

  // ---------------------------------------------------------------------------
  // Stage A: offset from robot to goal.
  // ---------------------------------------------------------------------------
  logic               a_vld_q;
  logic signed [16:0] a_dx_q, a_dy_q;
  logic signed [14:0] a_hd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    a_dx_q <= 17'(goal_x_i) - 17'(robot_x_i);
    a_dy_q <= 17'(goal_y_i) - 17'(robot_y_i);
    a_hd_q <= robot_heading_i;
  end

  // ---------------------------------------------------------------------------
  // Stage B: squares of the offset, and the starting vector of the CORDIC. A vector
  // in the left half plane is turned by pi so that the iterations only have to
  // cover the right half plane.
  // ---------------------------------------------------------------------------
  logic               b_vld_q;
  logic [31:0]        b_sqx_q, b_sqy_q;
  logic signed [43:0] b_cx_q, b_cy_q;
  logic signed [34:0] b_cz_q;
  logic signed [14:0] b_hd_q;

  logic signed [33:0] sqx, sqy;
  logic signed [43:0] x0, y0;

  always_comb begin
    sqx = a_dx_q * a_dx_q;
    sqy = a_dy_q * a_dy_q;
    x0  = {{3{a_dx_q[16]}}, a_dx_q, 24'd0};
    y0  = {{3{a_dy_q[16]}}, a_dy_q, 24'd0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_sqx_q <= sqx[31:0];
    b_sqy_q <= sqy[31:0];
    b_hd_q  <= a_hd_q;
    if (a_dx_q[16]) begin
      b_cx_q <= -x0;
      b_cy_q <= -y0;
      b_cz_q <= a_dy_q[16] ? -gtg_pkg::ANG_PI : gtg_pkg::ANG_PI;
    end else begin
      b_cx_q <= x0;
      b_cy_q <= y0;
      b_cz_q <= '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: squared distance and the exact arrival test. This stage is the entry
  // of the iteration section.
  // ---------------------------------------------------------------------------
  gtg_pkg::iter_t it_q [gtg_pkg::ITER_STAGES + 1];
  gtg_pkg::iter_t it_d [gtg_pkg::ITER_STAGES + 1];

  logic [32:0] d2;

  always_comb begin
    d2            = {1'b0, b_sqx_q} + {1'b0, b_sqy_q};
    it_d[0]       = it_q[0];
    it_d[0].vld   = b_vld_q;
    it_d[0].arr   = (d2 <= {1'b0, thr2_q});
    it_d[0].hd    = b_hd_q;
    it_d[0].rad   = {1'b0, d2};
    it_d[0].rem   = '0;
    it_d[0].root  = '0;
    it_d[0].cx    = b_cx_q;
    it_d[0].cy    = b_cy_q;
    it_d[0].cz    = b_cz_q;
  end

  // ---------------------------------------------------------------------------
  // Iteration section. Each stage takes one digit-by-digit step of the square root
  // (two radicand bits in, one root bit out) and one CORDIC vectoring step. Stages
  // past the end of a lane pass that lane through.
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < gtg_pkg::ITER_STAGES; k++) begin : g_iter
    always_comb begin
      logic [19:0]        rem_n;
      logic [19:0]        trial;
      logic signed [43:0] xs, ys;
      logic signed [34:0] ang;
      it_d[k + 1] = it_q[k];
      rem_n = {it_q[k].rem, it_q[k].rad[33:32]};
      trial = {1'b0, it_q[k].root, 2'b01};
      xs    = it_q[k].cx >>> k;
      ys    = it_q[k].cy >>> k;
      ang   = '0;
      if (k < gtg_pkg::SQRT_STEPS) begin
        it_d[k + 1].rad = {it_q[k].rad[31:0], 2'b00};
        if (rem_n >= trial) begin
          it_d[k + 1].rem  = 18'(rem_n - trial);
          it_d[k + 1].root = {it_q[k].root[15:0], 1'b1};
        end else begin
          it_d[k + 1].rem  = rem_n[17:0];
          it_d[k + 1].root = {it_q[k].root[15:0], 1'b0};
        end
      end
      if (k < gtg_pkg::CORDIC_STEPS) begin
        ang = $signed({3'b000, gtg_pkg::ATAN_TAB[k]});
        if (!it_q[k].cy[43]) begin
          it_d[k + 1].cx = it_q[k].cx + ys;
          it_d[k + 1].cy = it_q[k].cy - xs;
          it_d[k + 1].cz = it_q[k].cz + ang;
        end else begin
          it_d[k + 1].cx = it_q[k].cx - ys;
          it_d[k + 1].cy = it_q[k].cy + xs;
          it_d[k + 1].cz = it_q[k].cz - ang;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= gtg_pkg::ITER_STAGES; i++) begin
        it_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i <= gtg_pkg::ITER_STAGES; i++) begin
        it_q[i] <= it_d[i];
      end
    end
  end

  gtg_pkg::iter_t fin;
  assign fin = it_q[gtg_pkg::ITER_STAGES];

  // ---------------------------------------------------------------------------
  // Stage P1: forward speed product and the raw heading error.
  // ---------------------------------------------------------------------------
  logic               p1_vld_q, p1_arr_q;
  logic [32:0]        p1_lin_q;
  logic signed [34:0] p1_err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
    end else begin
      p1_vld_q <= fin.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_arr_q <= fin.arr;
    p1_lin_q <= linear_gain_q * fin.root;
    p1_err_q <= fin.cz - $signed({{2{fin.hd[14]}}, fin.hd, 18'd0});
  end

  // ---------------------------------------------------------------------------
  // Stage P2: round and saturate the forward speed; wrap the error into [-pi, pi).
  // The error never lies more than one turn outside that range, so a single
  // correction is enough.
  // ---------------------------------------------------------------------------
  logic               p2_vld_q, p2_arr_q;
  logic [15:0]        p2_lin_q;
  logic signed [32:0] p2_err_q;

  logic [33:0]        lin_rnd;
  logic [25:0]        lin_sh;
  logic signed [34:0] err_w;

  always_comb begin
    lin_rnd = {1'b0, p1_lin_q} + 34'd128;
    lin_sh  = lin_rnd[33:8];
    if (p1_err_q >= gtg_pkg::ANG_PI) begin
      err_w = p1_err_q - gtg_pkg::ANG_TWO_PI;
    end else if (p1_err_q < -gtg_pkg::ANG_PI) begin
      err_w = p1_err_q + gtg_pkg::ANG_TWO_PI;
    end else begin
      err_w = p1_err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_vld_q <= 1'b0;
    end else begin
      p2_vld_q <= p1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p2_arr_q <= p1_arr_q;
    p2_lin_q <= (lin_sh > 26'd65535) ? 16'hFFFF : lin_sh[15:0];
    p2_err_q <= err_w[32:0];
  end

  // ---------------------------------------------------------------------------
  // Stage P3: turn rate product.
  // ---------------------------------------------------------------------------
  logic               p3_vld_q, p3_arr_q;
  logic [15:0]        p3_lin_q;
  logic signed [49:0] p3_turn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p3_vld_q <= 1'b0;
    end else begin
      p3_vld_q <= p2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p3_arr_q  <= p2_arr_q;
    p3_lin_q  <= p2_lin_q;
    p3_turn_q <= $signed({1'b0, angular_gain_q}) * p2_err_q;
  end

  // ---------------------------------------------------------------------------
  // Stage P4: round and saturate the turn rate and drive the result ports. An
  // arrived request reports zero speeds.
  // ---------------------------------------------------------------------------
  logic signed [49:0] turn_rnd;
  logic signed [19:0] turn_sh;
  logic signed [15:0] turn_sat;

  always_comb begin
    turn_rnd = p3_turn_q + 50'sd536870912;
    turn_sh  = turn_rnd[49:30];
    if (turn_sh > 20'sd32767) begin
      turn_sat = 16'sh7FFF;
    end else if (turn_sh < -20'sd32768) begin
      turn_sat = -16'sh8000;
    end else begin
      turn_sat = turn_sh[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= p3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    arrived_o      <= p3_arr_q;
    linear_speed_o <= p3_arr_q ? 16'd0 : p3_lin_q;
    turn_rate_o    <= p3_arr_q ? 16'sd0 : turn_sat;
  end

endmodule
